### design/fqbs_pkg.sv
// ----------------------------------------------------------------------------
// fqbs_pkg
// Types, constants and coefficient banks for the Q15 FIR with bank select.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fqbs_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int RATE_W   = 18;
    localparam int CFG_IDX_W = 2;

    // Taps that carry a nonzero coefficient in any bank.
    localparam int BANK_LEN = 5;
    // Sum of up to BANK_LEN samples needs three extra bits.
    localparam int SUM_W    = SAMPLE_W + 3;
    localparam int PROD_W   = SUM_W + COEF_W;
    localparam int Q_SHIFT  = 15;

    localparam logic [RATE_W-1:0] RATE_48K = 18'd48000;

    localparam logic signed [COEF_W-1:0] COEF_PASS = 16'sd32767;
    localparam logic signed [COEF_W-1:0] COEF_48K  = 16'sd3000;
    localparam logic signed [COEF_W-1:0] COEF_44K  = 16'sd3276;

    typedef logic [1:0] bank_t;
    localparam bank_t BANK_PASS = 2'd0;
    localparam bank_t BANK_44K  = 2'd1;
    localparam bank_t BANK_48K  = 2'd2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_ANC_ENABLE = 2'd0;
    localparam cfg_idx_t REG_SAMPLE_RATE = 2'd1;

    // Stage 1 payload: windowed sample sum, current sample and bank.
    typedef struct packed {
        logic signed [SUM_W-1:0]    tap_sum;
        logic signed [SAMPLE_W-1:0] sample;
        bank_t                      bank;
    } win_t;

    function automatic logic signed [COEF_W-1:0] coef_of(input bank_t bank);
        logic signed [COEF_W-1:0] coef;
        unique case (bank)
            BANK_PASS: coef = COEF_PASS;
            BANK_44K:  coef = COEF_44K;
            BANK_48K:  coef = COEF_48K;
            default:   coef = '0;
        endcase
        return coef;
    endfunction

endpackage

### design/fqbs_window.sv
// ----------------------------------------------------------------------------
// fqbs_window
// History line of recent samples and the sum over the nonzero taps, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fqbs_window #(
    parameter int TAP_COUNT = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 load,
    input  logic signed [fqbs_pkg::SAMPLE_W-1:0] sample_in,
    input  logic                                 first_of_block,
    input  fqbs_pkg::bank_t                      bank,
    output fqbs_pkg::win_t                       win
);

    // Only the leading taps have nonzero coefficients in any bank, so the
    // history keeps just the samples those taps read.
    localparam int TAP_USED   = (TAP_COUNT < fqbs_pkg::BANK_LEN) ?
                                TAP_COUNT : fqbs_pkg::BANK_LEN;
    localparam int HIST_DEPTH = TAP_USED - 1;

    logic signed [fqbs_pkg::SUM_W-1:0] sum_next;
    fqbs_pkg::win_t                    win_reg;

    generate
        if (HIST_DEPTH > 0) begin : g_hist
            logic signed [fqbs_pkg::SAMPLE_W-1:0] hist_reg  [HIST_DEPTH];
            logic signed [fqbs_pkg::SAMPLE_W-1:0] hist_next [HIST_DEPTH];

            // A block start treats all older samples as zero.
            always_comb begin
                sum_next = fqbs_pkg::SUM_W'(sample_in);
                for (int j = 0; j < HIST_DEPTH; j++) begin
                    if (!first_of_block) begin
                        sum_next = sum_next + fqbs_pkg::SUM_W'(hist_reg[j]);
                    end
                end
            end

            always_comb begin
                hist_next[0] = sample_in;
                for (int k = 1; k < HIST_DEPTH; k++) begin
                    hist_next[k] = first_of_block ? '0 : hist_reg[k-1];
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    for (int k = 0; k < HIST_DEPTH; k++) begin
                        hist_reg[k] <= '0;
                    end
                end else if (load) begin
                    for (int k = 0; k < HIST_DEPTH; k++) begin
                        hist_reg[k] <= hist_next[k];
                    end
                end
            end
        end else begin : g_nohist
            assign sum_next = fqbs_pkg::SUM_W'(sample_in);
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (load) begin
            win_reg.tap_sum <= sum_next;
            win_reg.sample  <= sample_in;
            win_reg.bank    <= bank;
        end
    end

    assign win = win_reg;

endmodule

### design/fqbs_scale.sv
// ----------------------------------------------------------------------------
// fqbs_scale
// Coefficient lookup and the single registered multiply of the filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fqbs_scale (
    input  logic                                aclk,
    input  logic                                load,
    input  fqbs_pkg::win_t                      win,
    output logic signed [fqbs_pkg::PROD_W-1:0]  prod
);

    logic signed [fqbs_pkg::SUM_W-1:0]  operand;
    logic signed [fqbs_pkg::COEF_W-1:0] coef;
    logic signed [fqbs_pkg::PROD_W-1:0] prod_next;
    logic signed [fqbs_pkg::PROD_W-1:0] prod_reg;

    // The noise-cancelling banks share one coefficient over all their taps,
    // so the window sum is scaled once. The passthrough bank uses tap 0 only.
    always_comb begin
        if (win.bank == fqbs_pkg::BANK_PASS) begin
            operand = fqbs_pkg::SUM_W'(win.sample);
        end else begin
            operand = win.tap_sum;
        end
        coef      = fqbs_pkg::coef_of(win.bank);
        prod_next = fqbs_pkg::PROD_W'(operand) * fqbs_pkg::PROD_W'(coef);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

### design/fir_filter_q15_bank_select.sv
// Each accepted input beat passes the window sum, product and output registers in order.
// Throughput: one sample per cycle while m_ready holds, set by the three-stage pipeline
// (window sum, multiply, output register) with per-stage bubble collapsing.
// Reset clears the sample history, all valid flags, and restores
// anc_enable to 0 and sample_rate_hz to 44100.
// ----------------------------------------------------------------------------
// fir_filter_q15_bank_select
// Q15 FIR filter whose coefficient bank is chosen by ANC enable and rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fir_filter_q15_bank_select #(
    parameter int TAP_COUNT = 64
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [fqbs_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [fqbs_pkg::RATE_W-1:0]            cfg_data,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [fqbs_pkg::SAMPLE_W-1:0]   s_sample_in,
    input  logic                                   s_first_of_block,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [fqbs_pkg::SAMPLE_W-1:0]   m_sample_out
);

    logic                                  anc_enable_reg;
    logic [fqbs_pkg::RATE_W-1:0]           sample_rate_reg;
    fqbs_pkg::bank_t                       bank_sel;

    logic                                  v1_reg, v1_next;
    logic                                  v2_reg, v2_next;
    logic                                  vo_reg, vo_next;
    logic                                  accept, load2, load_o, en1, en2;

    fqbs_pkg::win_t                        win;
    logic signed [fqbs_pkg::PROD_W-1:0]    prod;
    logic signed [fqbs_pkg::SAMPLE_W-1:0]  sample_out_reg;

    // Configuration writes are always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            anc_enable_reg  <= 1'b0;
            sample_rate_reg <= 18'd44100;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == fqbs_pkg::REG_ANC_ENABLE) begin
                anc_enable_reg <= cfg_data[0];
            end else if (cfg_index == fqbs_pkg::REG_SAMPLE_RATE) begin
                sample_rate_reg <= cfg_data;
            end
        end
    end

    always_comb begin
        if (!anc_enable_reg) begin
            bank_sel = fqbs_pkg::BANK_PASS;
        end else if (sample_rate_reg == fqbs_pkg::RATE_48K) begin
            bank_sel = fqbs_pkg::BANK_48K;
        end else begin
            bank_sel = fqbs_pkg::BANK_44K;
        end
    end

    // Each stage moves forward when the stage after it is empty or moving.
    always_comb begin
        load_o  = v2_reg && (!vo_reg || m_ready);
        en2     = !v2_reg || load_o;
        load2   = v1_reg && en2;
        en1     = !v1_reg || load2;
        accept  = s_valid && en1;

        v1_next = accept ? 1'b1 : (load2 ? 1'b0 : v1_reg);
        v2_next = load2 ? 1'b1 : (load_o ? 1'b0 : v2_reg);
        vo_next = load_o || (vo_reg && !m_ready);
    end

    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            vo_reg <= vo_next;
        end
    end

    fqbs_window #(
        .TAP_COUNT(TAP_COUNT)
    ) u_window (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (accept),
        .sample_in      (s_sample_in),
        .first_of_block (s_first_of_block),
        .bank           (bank_sel),
        .win            (win)
    );

    fqbs_scale u_scale (
        .aclk (aclk),
        .load (load2),
        .win  (win),
        .prod (prod)
    );

    // Output is the product shifted right by Q_SHIFT, low 16 bits kept.
    always_ff @(posedge aclk) begin
        if (load_o) begin
            sample_out_reg <= prod[fqbs_pkg::Q_SHIFT +: fqbs_pkg::SAMPLE_W];
        end
    end

    assign m_valid      = vo_reg;
    assign m_sample_out = sample_out_reg;

endmodule
